@@ rtl/core/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, helper functions and the command
// struct shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned LenPos     = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		begin
			unique case (t)
				6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
				6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
				6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
				6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
				6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
				6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
				6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
				6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
				6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
				6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
				6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
				6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
				6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
				6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
				6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
				6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
				6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
				6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
				6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
				6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
				6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
				6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
				6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
				6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
				6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
				6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
				6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
				6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
				6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
				6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
				6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
				6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
				default: k = 32'h0;
			endcase
			return k;
		end
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		begin
			unique case (i)
				3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
				3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
				3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
				3'd6: h = 32'h1F83D9AB; 3'd7: h = 32'h5BE0CD19;
				default: h = 32'h0;
			endcase
			return h;
		end
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Byte source for a block write.
	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	typedef struct packed {
		logic       wr_byte;    // write one byte into the block
		byte_src_t  src;
		logic [5:0] wr_pos;
		logic       count_byte; // bump the message length
		logic       rnd_start;  // load working variables from hash words
		logic       rnd_step;   // run one round
		logic [5:0] rnd_idx;
		logic       rnd_fold;   // add working variables into hash words
		logic       digest_ld;  // capture digest into output register
		logic       restart;    // reload initial hash, clear length
	} dp_cmd_t;

endpackage

@@ rtl/core/sha256_byte_stream_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hash
// Hashes a message fed one byte per transaction and returns its digest.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries data_byte, qualified by has_byte, and
// end_of_message. An item with end_of_message closes the message after its own
// byte; the block pads, appends the 64-bit bit length and presents the 256-bit
// digest as four 64-bit big-endian parts on the output channel.
// Sequence: a byte that does not fill the block is written and counted when it
// is accepted. The 64th byte of a block starts the compression: a setup step, 64
// rounds (one round a cycle in the shared round unit) and a fold step.
// End of message writes padding one byte a cycle up to the block end, runs one
// or two compressions and loads the digest register. The worst case is a pad
// byte landing at offset 56: eight pad bytes, a compression, a block of padding,
// a second compression and the digest load come before the digest is offered.
// While the digest waits, in_ready stays low; a stalled receiver holds the
// block. Reset restores the initial hash values and clears the length; the
// block buffer needs no clearing because it is always written before read.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_part_0,
	output logic [63:0] digest_part_1,
	output logic [63:0] digest_part_2,
	output logic [63:0] digest_part_3
);

	sha256_pkg::dp_cmd_t cmd;
	logic [255:0]        digest;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .has_byte, .end_of_message,
		.out_valid, .out_ready, .cmd
	);

	sha256_dp u_dp (
		.clk, .arst_n, .cmd, .data_byte, .digest
	);

	assign digest_part_0 = digest[255:192];
	assign digest_part_1 = digest[191:128];
	assign digest_part_2 = digest[127:64];
	assign digest_part_3 = digest[63:0];

endmodule

@@ rtl/core/sha256_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, schedule window, one-round compression unit and length count.
// ----------------------------------------------------------------------------
module sha256_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::dp_cmd_t  cmd,
	input  logic [7:0]           data_byte,
	output logic [255:0]         digest
);

	// The block is held as sixteen big-endian words, written one byte lane at a time.
	sha256_pkg::word_t       blk_q [16];
	sha256_pkg::word_t       w_q [16];
	sha256_pkg::word_t       h_q [8];
	sha256_pkg::word_t       v_q [8];
	logic [63:0]             total_q;
	logic [255:0]            digest_q;
	logic [63:0]             bits;
	logic [7:0]              wr_data;
	logic [5:0]              t;
	sha256_pkg::word_t       wt, s0, s1, ch, mj, t1, t2, a15, a2;

	assign bits = {total_q[60:0], 3'b000};
	assign t    = cmd.rnd_idx;

	always_comb begin
		unique case (cmd.src)
			sha256_pkg::SRC_DATA: wr_data = data_byte;
			sha256_pkg::SRC_PAD:  wr_data = sha256_pkg::PadByte;
			sha256_pkg::SRC_ZERO: wr_data = 8'h00;
			sha256_pkg::SRC_LEN:  wr_data = bits[8 * (7 - cmd.wr_pos[2:0]) +: 8];
			default:              wr_data = 8'h00;
		endcase
	end

	always_comb begin
		a15 = w_q[4'(t - 6'd15)];
		a2  = w_q[4'(t - 6'd2)];
		if (t < 6'd16) begin
			wt = blk_q[t[3:0]];
		end else begin
			wt = w_q[t[3:0]] + w_q[4'(t - 6'd7)]
				+ (sha256_pkg::rotr(a15, 7) ^ sha256_pkg::rotr(a15, 18) ^ (a15 >> 3))
				+ (sha256_pkg::rotr(a2, 17) ^ sha256_pkg::rotr(a2, 19) ^ (a2 >> 10));
		end
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		s0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		s1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		t1 = v_q[7] + s1 + ch + sha256_pkg::round_k(t) + wt;
		t2 = s0 + mj;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) blk_q[cmd.wr_pos[5:2]][8 * (3 - cmd.wr_pos[1:0]) +: 8] <= wr_data;
		if (cmd.rnd_step) w_q[t[3:0]] <= wt;
		if (cmd.rnd_start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.rnd_step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.digest_ld) begin
			for (int i = 0; i < 8; i++) digest_q[255 - 32 * i -: 32] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
			total_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_h(3'(i));
				total_q <= '0;
			end else begin
				if (cmd.rnd_fold) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.count_byte) total_q <= total_q + 64'd1;
			end
		end
	end

	assign digest = digest_q;

endmodule

@@ rtl/core/sha256_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression rounds and digest delivery.
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 has_byte,
	input  logic                 end_of_message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sha256_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_START = 7'b0000010,
		S_ROUND = 7'b0000100,
		S_FOLD  = 7'b0001000,
		S_PAD   = 7'b0010000,
		S_DIG   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] rnd_q, rnd_d;
	logic       fin_q, fin_d;   // the 0x80 pad byte has been written
	logic       eom_q, eom_d;   // the message closes, padding follows this block
	logic       last_q, last_d; // this block carries the length
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_d = state_q; fill_d = fill_q; rnd_d = rnd_q;
		fin_d = fin_q; eom_d = eom_q; last_d = last_q;
		cmd = '0;
		cmd.src = sha256_pkg::SRC_DATA;
		cmd.wr_pos = fill_q;
		cmd.rnd_idx = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					fin_d = 1'b0;
					eom_d = end_of_message;
					last_d = 1'b0;
					if (has_byte) begin
						cmd.wr_byte = 1'b1;
						cmd.count_byte = 1'b1;
						fill_d = fill_q + 6'd1;
						if (fill_q == 6'd63) state_d = S_START;
						else if (end_of_message) state_d = S_PAD;
					end else if (end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				// One byte a cycle: 0x80 at the fill position, then zeros,
				// then the length in the last eight bytes of the final block.
				cmd.wr_byte = 1'b1;
				if (!fin_q) cmd.src = sha256_pkg::SRC_PAD;
				else if (last_q && fill_q >= 6'(sha256_pkg::LenPos))
					cmd.src = sha256_pkg::SRC_LEN;
				else cmd.src = sha256_pkg::SRC_ZERO;
				fin_d = 1'b1;
				fill_d = fill_q + 6'd1;
				if (!last_q && !fin_q && fill_q <= 6'(sha256_pkg::LenPos - 1))
					last_d = 1'b1;
				if (fill_q == 6'd63) state_d = S_START;
				else if (!last_q && fin_q && fill_q == 6'(sha256_pkg::LenPos - 1)) begin
					last_d = 1'b1;
				end
			end
			S_START: begin
				cmd.rnd_start = 1'b1;
				rnd_d = '0;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.rnd_step = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == 6'(sha256_pkg::Rounds - 1)) state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.rnd_fold = 1'b1;
				if (last_q) state_d = S_DIG;
				else if (eom_q) state_d = S_PAD;
				else state_d = S_IDLE;
			end
			S_DIG: begin
				cmd.digest_ld = 1'b1;
				cmd.restart = 1'b1;
				fill_d = '0;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; fill_q <= '0; rnd_q <= '0;
			fin_q <= 1'b0; eom_q <= 1'b0; last_q <= 1'b0;
		end else begin
			state_q <= state_d; fill_q <= fill_d; rnd_q <= rnd_d;
			fin_q <= fin_d; eom_q <= eom_d; last_q <= last_d;
		end
	end

endmodule
